[src/probabilistic_step_sequencer_core_macros.svh]
// Assertion helpers for the core RTL file.
`ifndef PROBABILISTIC_STEP_SEQUENCER_CORE_MACROS_SVH
`define PROBABILISTIC_STEP_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define PSSEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define PSSEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define PSSEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PSSEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/psseq_pkg.sv]
package psseq_pkg;

	localparam int unsigned STEP_W    = 3;
	localparam int unsigned CHAN_W    = 4;
	localparam int unsigned TICK_W    = 8;
	localparam int unsigned SAMPLE_W  = 15;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 64;

	localparam logic signed [SAMPLE_W-1:0] THRESHOLD_MV = 15'sd2000;

	localparam logic [3:0] MAX_JUMP_SEL    = 4'd8;
	localparam logic [4:0] MAX_CHANNEL_SEL = 5'd16;

	localparam logic [7:0]  AUTORESET_RST = 8'd16;
	localparam logic [63:0] PROB_RST      = 64'h0;
	localparam logic [31:0] JUMP_A_RST    = 32'h1876_5432;
	localparam logic [31:0] JUMP_B_RST    = 32'h8888_8888;
	localparam logic [39:0] CHANNEL_RST   = 40'd282600803393;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AUTORESET = 3'd0,
		REG_PROB      = 3'd1,
		REG_JUMP_A    = 3'd2,
		REG_JUMP_B    = 3'd3,
		REG_CHANNEL   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  autoreset_length;
		logic [63:0] prob_table;
		logic [31:0] jump_a_table;
		logic [31:0] jump_b_table;
		logic [39:0] channel_table;
	} cfg_t;

	typedef struct packed {
		logic              clock_was_high;
		logic              reset_was_high;
		logic [STEP_W-1:0] current_step;
		logic [TICK_W-1:0] tick_count;
	} state_t;

	typedef struct packed {
		state_t            state;
		logic              emit;
		logic              rst_edge;
		logic              autoreset;
		logic [CHAN_W-1:0] channel;
	} next_t;

endpackage

[src/psseq_next.sv]
module psseq_next (
	input  psseq_pkg::state_t                    state,
	input  psseq_pkg::cfg_t                      cfg,
	input  logic signed [psseq_pkg::SAMPLE_W-1:0] clock_sample,
	input  logic signed [psseq_pkg::SAMPLE_W-1:0] reset_sample,
	input  logic [7:0]                           rand_prob,
	input  logic [psseq_pkg::STEP_W-1:0]         rand_step,
	input  logic [psseq_pkg::CHAN_W-1:0]         rand_chan,
	output psseq_pkg::next_t                     nxt
);

	logic                          clk_high;
	logic                          rst_high;
	logic                          clk_edge;
	logic                          rst_edge;
	logic [psseq_pkg::TICK_W-1:0]  tick_inc;
	logic                          auto_hit;
	logic [psseq_pkg::STEP_W-1:0]  cur;
	logic [7:0]                    code;
	logic [31:0]                   jump_tbl;
	logic [3:0]                    tgt;
	logic [psseq_pkg::STEP_W-1:0]  jump_step;
	logic [psseq_pkg::STEP_W-1:0]  new_step;
	logic [5:0]                    chan_off;
	logic [4:0]                    chan_sel;

	assign clk_high = clock_sample > psseq_pkg::THRESHOLD_MV;
	assign rst_high = reset_sample > psseq_pkg::THRESHOLD_MV;
	assign clk_edge = clk_high && !state.clock_was_high;
	assign rst_edge = rst_high && !state.reset_was_high;

	assign tick_inc = (state.tick_count == '1) ? state.tick_count : state.tick_count + 1'b1;
	assign auto_hit = (cfg.autoreset_length != '0) && (tick_inc >= cfg.autoreset_length);

	assign cur      = state.current_step;
	assign code     = cfg.prob_table[{cur, 3'b000} +: 8];
	assign jump_tbl = (rand_prob > code) ? cfg.jump_a_table : cfg.jump_b_table;
	assign tgt      = jump_tbl[{cur, 2'b00} +: 4];

	// Clamp out-of-range targets to the last step; zero picks a random step.
	always_comb begin
		if (tgt > psseq_pkg::MAX_JUMP_SEL) begin
			jump_step = '1;
		end else if (tgt == 4'd0) begin
			jump_step = rand_step;
		end else begin
			jump_step = 3'(tgt - 4'd1);
		end
	end

	always_comb begin
		if (clk_edge) begin
			new_step = (rst_edge || auto_hit) ? '0 : jump_step;
		end else begin
			new_step = rst_edge ? '0 : cur;
		end
	end

	always_comb begin
		nxt                      = '0;
		nxt.state.clock_was_high = clk_high;
		nxt.state.reset_was_high = rst_high;
		nxt.state.tick_count     = state.tick_count;
		nxt.state.current_step   = new_step;
		nxt.emit                 = clk_edge;
		nxt.rst_edge             = rst_edge;
		nxt.autoreset            = clk_edge && !rst_edge && auto_hit;
		if (clk_edge) begin
			if (rst_edge || auto_hit) begin
				nxt.state.tick_count = '0;
			end else begin
				nxt.state.tick_count = tick_inc;
			end
		end
		nxt.channel = chan_sel_to_chan(chan_sel);
	end

	assign chan_off = {new_step, 2'b00} + {3'b000, new_step};
	assign chan_sel = cfg.channel_table[chan_off +: 5];

	function automatic logic [psseq_pkg::CHAN_W-1:0] chan_sel_to_chan(input logic [4:0] sel);
		logic [psseq_pkg::CHAN_W-1:0] ch;
		if (sel > psseq_pkg::MAX_CHANNEL_SEL) begin
			ch = '1;
		end else if (sel == 5'd0) begin
			ch = rand_chan;
		end else begin
			ch = 4'(sel - 5'd1);
		end
		return ch;
	endfunction

endmodule

[src/probabilistic_step_sequencer_core.sv]
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    clock_sample, reset_sample, rand_prob,
//                                             rand_step, rand_chan
// out       source     out_valid / out_ready  step_index, channel_index
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input transaction per cycle while in_ready is high; its result, if any,
// appears in the next cycle from the output register. The step state updates at input accept.
// Input stalls only while the output register is full and not being taken.
// cfg_ready is always high. Reset clears edge history, step, tick count, the
// output valid and restores register defaults.
module probabilistic_step_sequencer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [psseq_pkg::SAMPLE_W-1:0] clock_sample,
	input  logic signed [psseq_pkg::SAMPLE_W-1:0] reset_sample,
	input  logic [7:0]                            rand_prob,
	input  logic [psseq_pkg::STEP_W-1:0]          rand_step,
	input  logic [psseq_pkg::CHAN_W-1:0]          rand_chan,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [psseq_pkg::STEP_W-1:0]          step_index,
	output logic [psseq_pkg::CHAN_W-1:0]          channel_index,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [psseq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psseq_pkg::CFG_DAT_W-1:0]       cfg_data
);

	`include "probabilistic_step_sequencer_core_macros.svh"

	psseq_pkg::cfg_t   cfg_q;
	psseq_pkg::state_t state_q;
	psseq_pkg::next_t  nxt;
	logic              out_valid_q;
	logic [psseq_pkg::STEP_W-1:0] step_q;
	logic [psseq_pkg::CHAN_W-1:0] chan_q;
	logic              in_acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.autoreset_length <= psseq_pkg::AUTORESET_RST;
			cfg_q.prob_table       <= psseq_pkg::PROB_RST;
			cfg_q.jump_a_table     <= psseq_pkg::JUMP_A_RST;
			cfg_q.jump_b_table     <= psseq_pkg::JUMP_B_RST;
			cfg_q.channel_table    <= psseq_pkg::CHANNEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (psseq_pkg::cfg_reg_t'(cfg_index))
				psseq_pkg::REG_AUTORESET: cfg_q.autoreset_length <= cfg_data[7:0];
				psseq_pkg::REG_PROB:      cfg_q.prob_table       <= cfg_data;
				psseq_pkg::REG_JUMP_A:    cfg_q.jump_a_table     <= cfg_data[31:0];
				psseq_pkg::REG_JUMP_B:    cfg_q.jump_b_table     <= cfg_data[31:0];
				psseq_pkg::REG_CHANNEL:   cfg_q.channel_table    <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	psseq_next u_next (
		.state        (state_q),
		.cfg          (cfg_q),
		.clock_sample (clock_sample),
		.reset_sample (reset_sample),
		.rand_prob    (rand_prob),
		.rand_step    (rand_step),
		.rand_chan    (rand_chan),
		.nxt          (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q <= nxt.state;
			end
			// Load a new result, or drop the old one once taken.
			if (in_acc && nxt.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && nxt.emit) begin
			step_q <= nxt.state.current_step;
			chan_q <= nxt.channel;
		end
	end

	assign out_valid     = out_valid_q;
	assign step_index    = step_q;
	assign channel_index = chan_q;

	`PSSEQ_ASSERT_NXT(a_edge_gives_result, clk, arst_n, in_acc && nxt.emit, out_valid)
	`PSSEQ_ASSERT_NXT(a_step_zero_on_reset, clk, arst_n,
		in_acc && nxt.emit && (nxt.rst_edge || nxt.autoreset),
		step_index == '0 && state_q.tick_count == '0)
	`PSSEQ_ASSERT_NXT(a_tick_held_without_edge, clk, arst_n, in_acc && !nxt.emit,
		state_q.tick_count == $past(state_q.tick_count))

endmodule
